// File: src/sclru_pkg.sv
// Package for the set-associative LRU cache model: state codes, command,
// outcome and configuration-register codes, fixed field widths.
// No dependencies.
package sclru_pkg;

  // Fixed widths of the interface fields
  localparam int CMD_W       = 2;
  localparam int OUTCOME_W   = 2;
  localparam int WAY_OUT_W   = 3;
  localparam int TOTAL_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SET_CFG_W   = 3;
  localparam int OFF_CFG_W   = 6;
  localparam int WAYS_CFG_W  = 4;
  // offset bits plus set bits, up to 63 + 7
  localparam int TAG_SHIFT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_IFETCH = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_IGNORED = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS        = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_reg_t;

  localparam logic [SET_CFG_W-1:0]  SET_BITS_RST    = 3'd4;
  localparam logic [OFF_CFG_W-1:0]  OFFSET_BITS_RST = 6'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST        = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

endpackage

// File: src/sclru_lru_pick.sv
// Registered LRU victim picker: a compare tree over the stamps of the
// eligible ways of one set. Self-contained, no package use.
module sclru_lru_pick #(
  parameter int WAYS    = 8,
  parameter int STAMP_W = 32,
  parameter int IDX_W   = 3
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [WAYS-1:0]                elig,
  input  logic [WAYS-1:0][STAMP_W-1:0]   stamps,
  output logic [IDX_W-1:0]               victim_r
);

  localparam int LEAVES = 1 << $clog2(WAYS);
  localparam int NODES  = 2 * LEAVES - 1;

  logic [NODES-1:0]              node_ok;
  logic [NODES-1:0][STAMP_W-1:0] node_stamp;
  logic [NODES-1:0][IDX_W-1:0]   node_idx;

  // Smaller stamp wins; a tie goes to the lower way.
  always_comb begin
    node_ok    = '0;
    node_stamp = '0;
    node_idx   = '0;
    for (int j = 0; j < LEAVES; j++) begin
      if (j < WAYS) begin
        node_ok[LEAVES-1+j]    = elig[j];
        node_stamp[LEAVES-1+j] = stamps[j];
        node_idx[LEAVES-1+j]   = IDX_W'(j);
      end
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (node_ok[2*n+1] && (!node_ok[2*n+2] || node_stamp[2*n+1] <= node_stamp[2*n+2])) begin
        node_stamp[n] = node_stamp[2*n+1];
        node_idx[n]   = node_idx[2*n+1];
      end else begin
        node_stamp[n] = node_stamp[2*n+2];
        node_idx[n]   = node_idx[2*n+2];
      end
      node_ok[n] = node_ok[2*n+1] | node_ok[2*n+2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      victim_r <= node_idx[0];
    end
  end

endmodule

// File: src/set_associative_lru_cache_model_core.sv
// Set-associative cache model with LRU replacement: top level.
// Depends on sclru_pkg and sclru_lru_pick.
//
// Each input beat is one access (command, byte address); each produces exactly one
// result beat with the outcome of the first access, the modify second-hit flag, the
// way used and the saturating hit/miss/eviction totals. A load, store or modify passes
// through accept, set read, tag compare with LRU tree and write back, which waits while
// the output register is full; an instruction load goes from accept straight to write
// back and touches no state. The next beat is accepted once the previous access has
// been written back, even while its result still waits in the output register. A
// modify's second access rides along in the same write back (the line gets the second
// stamp and the second hit is counted as well).
// All ways of a set live in one memory row (tags in one memory, valid+stamp in a
// second), so the whole set is read and written in one access. A per-set flag cleared
// at reset marks rows never written; such a row reads as all ways invalid, so no
// clearing pass runs after reset. Configuration writes are taken at any time
// (cfg_ready is always high) and must only be issued while the block is idle.
module set_associative_lru_cache_model_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64,
  parameter int STAMP_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // access channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sclru_pkg::CMD_W-1:0]           in_command,
  input  logic [ADDR_BITS-1:0]                  in_address,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sclru_pkg::OUTCOME_W-1:0]       out_outcome,
  output logic                                  out_second_hit,
  output logic [sclru_pkg::WAY_OUT_W-1:0]       out_way_used,
  output logic [sclru_pkg::TOTAL_W-1:0]         out_hit_total,
  output logic [sclru_pkg::TOTAL_W-1:0]         out_miss_total,
  output logic [sclru_pkg::TOTAL_W-1:0]         out_eviction_total,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sclru_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sclru_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TW    = sclru_pkg::TOTAL_W;

  typedef logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  tag_row_t;
  // per way: {valid, stamp}
  typedef logic [MAX_WAYS-1:0][STAMP_BITS:0]   meta_row_t;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] v, input logic [1:0] inc);
    logic [TW:0] s;
    s = {1'b0, v} + (TW+1)'(inc);
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sclru_pkg::SET_CFG_W-1:0]  set_bits_r;
  logic [sclru_pkg::OFF_CFG_W-1:0]  offset_bits_r;
  logic [sclru_pkg::WAYS_CFG_W-1:0] ways_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= sclru_pkg::SET_BITS_RST;
      offset_bits_r <= sclru_pkg::OFFSET_BITS_RST;
      ways_r        <= sclru_pkg::WAYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (sclru_pkg::cfg_reg_t'(cfg_index))
        sclru_pkg::CFG_SET_BITS:    set_bits_r    <= cfg_data[sclru_pkg::SET_CFG_W-1:0];
        sclru_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_data[sclru_pkg::OFF_CFG_W-1:0];
        sclru_pkg::CFG_WAYS:        ways_r        <= cfg_data[sclru_pkg::WAYS_CFG_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Clamp the set bits and the associativity to what the storage holds
  logic [sclru_pkg::SET_CFG_W-1:0] sbits_eff;
  logic [4:0]                      ways_eff;

  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      sbits_eff = sclru_pkg::SET_CFG_W'(MAX_SET_BITS);
    end else begin
      sbits_eff = set_bits_r;
    end
    if (ways_r == '0) begin
      ways_eff = 5'd1;
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and beat capture
  // ---------------------------------------------------------------------------
  sclru_pkg::state_t                state_r;
  logic [sclru_pkg::CMD_W-1:0]      cmd_r;
  logic [ADDR_BITS-1:0]             addr_r;
  logic [SET_W-1:0]                 set_r;
  logic [ADDR_BITS-1:0]             tag_r;

  logic                             out_free;
  logic                             ignore_acc;
  logic                             is_modify;
  logic                             wr_en;

  assign in_ready   = (state_r == sclru_pkg::ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign ignore_acc = (cmd_r == sclru_pkg::CMD_IFETCH);
  assign is_modify  = (cmd_r == sclru_pkg::CMD_MODIFY);
  assign wr_en      = (state_r == sclru_pkg::ST_WRITE) && out_free && !ignore_acc;

  // Address split: set index above the offset, tag above both
  logic [ADDR_BITS-1:0]                 off_shift;
  logic [SET_W-1:0]                     set_mask;
  logic [SET_W-1:0]                     set_idx;
  logic [sclru_pkg::TAG_SHIFT_W-1:0]    tag_shamt;
  logic [ADDR_BITS-1:0]                 tag_val;

  always_comb begin
    off_shift = addr_r >> offset_bits_r;
    set_mask  = ~({SET_W{1'b1}} << sbits_eff);
    set_idx   = off_shift[SET_W-1:0] & set_mask;
    tag_shamt = sclru_pkg::TAG_SHIFT_W'(offset_bits_r) + sclru_pkg::TAG_SHIFT_W'(sbits_eff);
    tag_val   = addr_r >> tag_shamt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sclru_pkg::ST_IDLE;
    end else begin
      case (state_r)
        sclru_pkg::ST_IDLE: begin
          if (in_valid) begin
            // instruction loads skip the set access
            state_r <= (in_command == sclru_pkg::CMD_IFETCH) ? sclru_pkg::ST_WRITE
                                                              : sclru_pkg::ST_READ;
          end
        end
        sclru_pkg::ST_READ:  state_r <= sclru_pkg::ST_CMP;
        sclru_pkg::ST_CMP:   state_r <= sclru_pkg::ST_WRITE;
        sclru_pkg::ST_WRITE: begin
          if (out_free) begin
            state_r <= sclru_pkg::ST_IDLE;
          end
        end
        default: state_r <= sclru_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
    end
    if (state_r == sclru_pkg::ST_READ) begin
      set_r <= set_idx;
      tag_r <= tag_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Set memories: one row per set holds every way
  // ---------------------------------------------------------------------------
  tag_row_t  tag_mem  [SETS];
  meta_row_t meta_mem [SETS];
  tag_row_t  tag_q;
  meta_row_t meta_q;
  tag_row_t  tag_wr;
  meta_row_t meta_wr;
  logic [SETS-1:0] row_init_r;

  always_ff @(posedge clk) begin
    if (state_r == sclru_pkg::ST_READ) begin
      tag_q  <= tag_mem[set_idx];
      meta_q <= meta_mem[set_idx];
    end
    if (wr_en) begin
      tag_mem[set_r]  <= tag_wr;
      meta_mem[set_r] <= meta_wr;
    end
  end

  // A row never written reads as all ways invalid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (wr_en) begin
      row_init_r[set_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare stage: tag match, empty-way search, LRU tree
  // ---------------------------------------------------------------------------
  logic [MAX_WAYS-1:0]                 line_ok;
  logic [MAX_WAYS-1:0]                 way_in_use;
  logic [MAX_WAYS-1:0]                 eligible;
  logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stamps;
  logic                                hit_any;
  logic [WAY_W-1:0]                    hit_way;
  logic                                empty_any;
  logic [WAY_W-1:0]                    empty_way;

  logic                                hit_any_r;
  logic [WAY_W-1:0]                    hit_way_r;
  logic                                empty_any_r;
  logic [WAY_W-1:0]                    empty_way_r;
  logic [WAY_W-1:0]                    victim_r;

  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      line_ok[i]    = meta_q[i][STAMP_BITS] & row_init_r[set_r];
      way_in_use[i] = (i < int'(ways_eff));
      eligible[i]   = line_ok[i] & way_in_use[i];
      stamps[i]     = meta_q[i][STAMP_BITS-1:0];
    end
    // lowest matching way wins
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (eligible[i] && tag_q[i] == tag_r) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(i);
      end
    end
    // highest empty way wins
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (way_in_use[i] && !line_ok[i]) begin
        empty_any = 1'b1;
        empty_way = WAY_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sclru_pkg::ST_CMP) begin
      hit_any_r   <= hit_any;
      hit_way_r   <= hit_way;
      empty_any_r <= empty_any;
      empty_way_r <= empty_way;
    end
  end

  sclru_lru_pick #(
    .WAYS    (MAX_WAYS),
    .STAMP_W (STAMP_BITS),
    .IDX_W   (WAY_W)
  ) u_pick (
    .clk      (clk),
    .en       (state_r == sclru_pkg::ST_CMP),
    .elig     (eligible),
    .stamps   (stamps),
    .victim_r (victim_r)
  );

  // ---------------------------------------------------------------------------
  // Write-back stage: update the row, stamp, totals and the result register
  // ---------------------------------------------------------------------------
  logic [STAMP_BITS-1:0]          access_stamp_r;
  logic [TW-1:0]                  hit_cnt_r;
  logic [TW-1:0]                  miss_cnt_r;
  logic [TW-1:0]                  evict_cnt_r;

  logic [WAY_W-1:0]               pick_way;
  logic [STAMP_BITS-1:0]          stamp_new;
  logic [1:0]                     hit_inc;
  logic [1:0]                     miss_inc;
  logic [1:0]                     evict_inc;
  logic [sclru_pkg::OUTCOME_W-1:0] outcome;
  logic [TW-1:0]                  hit_cnt_nxt;
  logic [TW-1:0]                  miss_cnt_nxt;
  logic [TW-1:0]                  evict_cnt_nxt;

  always_comb begin
    if (hit_any_r) begin
      pick_way = hit_way_r;
    end else if (empty_any_r) begin
      pick_way = empty_way_r;
    end else begin
      pick_way = victim_r;
    end
    // a modify takes a second stamp for its always-hitting second access
    stamp_new = access_stamp_r + (is_modify ? STAMP_BITS'(2) : STAMP_BITS'(1));

    for (int i = 0; i < MAX_WAYS; i++) begin
      meta_wr[i] = {meta_q[i][STAMP_BITS] & row_init_r[set_r], meta_q[i][STAMP_BITS-1:0]};
    end
    meta_wr[pick_way] = {1'b1, stamp_new};
    tag_wr            = tag_q;
    tag_wr[pick_way]  = tag_r;

    hit_inc   = '0;
    miss_inc  = '0;
    evict_inc = '0;
    if (ignore_acc) begin
      outcome = sclru_pkg::OUT_IGNORED;
    end else begin
      hit_inc = {1'b0, hit_any_r} + {1'b0, is_modify};
      if (hit_any_r) begin
        outcome = sclru_pkg::OUT_HIT;
      end else if (empty_any_r) begin
        outcome  = sclru_pkg::OUT_FILL;
        miss_inc = 2'd1;
      end else begin
        outcome   = sclru_pkg::OUT_EVICT;
        miss_inc  = 2'd1;
        evict_inc = 2'd1;
      end
    end
    hit_cnt_nxt   = sat_add(hit_cnt_r, hit_inc);
    miss_cnt_nxt  = sat_add(miss_cnt_r, miss_inc);
    evict_cnt_nxt = sat_add(evict_cnt_r, evict_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_stamp_r <= '0;
      hit_cnt_r      <= '0;
      miss_cnt_r     <= '0;
      evict_cnt_r    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state_r == sclru_pkg::ST_WRITE && out_free) begin
        if (!ignore_acc) begin
          access_stamp_r <= stamp_new;
        end
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load only when the output register is free
  always_ff @(posedge clk) begin
    if (state_r == sclru_pkg::ST_WRITE && out_free) begin
      out_outcome        <= outcome;
      out_second_hit     <= is_modify;
      out_way_used       <= ignore_acc ? '0 : sclru_pkg::WAY_OUT_W'(pick_way);
      out_hit_total      <= hit_cnt_nxt;
      out_miss_total     <= miss_cnt_nxt;
      out_eviction_total <= evict_cnt_nxt;
    end
  end

endmodule

// File: src/sclru_chk.sv
// Port-level checker for the set-associative LRU cache model and its bind.
// Depends on sclru_pkg; binds to set_associative_lru_cache_model_core.
module sclru_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sclru_pkg::OUTCOME_W-1:0]   out_outcome,
  input logic                              out_second_hit,
  input logic [sclru_pkg::WAY_OUT_W-1:0]   out_way_used,
  input logic [sclru_pkg::TOTAL_W-1:0]     out_hit_total,
  input logic [sclru_pkg::TOTAL_W-1:0]     out_miss_total,
  input logic [sclru_pkg::TOTAL_W-1:0]     out_eviction_total
);

  logic                          seen_r;
  logic [sclru_pkg::TOTAL_W-1:0] last_hit_r;
  logic [sclru_pkg::TOTAL_W-1:0] last_miss_r;
  logic [sclru_pkg::TOTAL_W-1:0] last_evict_r;

  // remember the totals of the last delivered beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
    if (out_valid && out_ready) begin
      last_hit_r   <= out_hit_total;
      last_miss_r  <= out_miss_total;
      last_evict_r <= out_eviction_total;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome) && $stable(out_way_used)
      && $stable(out_hit_total) && $stable(out_miss_total))
    else $error("result beat changed while stalled");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == sclru_pkg::OUT_IGNORED |-> !out_second_hit && out_way_used == '0)
    else $error("ignored access reports a way or a second hit");

  a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_hit_total >= last_hit_r && out_miss_total >= last_miss_r
      && out_eviction_total >= last_evict_r)
    else $error("running total decreased");

  a_ignored_keeps_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r && out_outcome == sclru_pkg::OUT_IGNORED |->
      out_hit_total == last_hit_r && out_miss_total == last_miss_r
      && out_eviction_total == last_evict_r)
    else $error("ignored access changed a total");

  a_second_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_hit |-> out_hit_total != '0 && out_outcome != sclru_pkg::OUT_IGNORED)
    else $error("second hit without a counted hit");

endmodule

bind set_associative_lru_cache_model_core sclru_chk u_sclru_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_outcome        (out_outcome),
  .out_second_hit     (out_second_hit),
  .out_way_used       (out_way_used),
  .out_hit_total      (out_hit_total),
  .out_miss_total     (out_miss_total),
  .out_eviction_total (out_eviction_total)
);

// File: tb/tb_top.sv
// Self-checking testbench for set_associative_lru_cache_model_core: a cache mirror class
// predicts every result beat from the accepted accesses. Depends on sclru_pkg and the
// core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SET_BITS     = 6;
  localparam int MAX_WAYS         = 8;
  localparam int ADDR_BITS        = 64;
  localparam int STAMP_BITS       = 32;
  localparam int LINES            = (1 << MAX_SET_BITS) * MAX_WAYS;
  // Random phases after the directed part; each one runs a fresh register setting.
  localparam int RANDOM_PHASES    = 12;
  localparam int ACCESSES_PER_PHASE = 121;
  // Receiver hold-off that backs the pipeline up into the access channel.
  localparam int HOLD_OFF_CYCLES  = 300;
  // Write back plus output register, with margin.
  localparam int DRAIN_CYCLES     = 16;
  // ~1500 beats, each at worst a long sender gap plus a long receiver stall,
  // plus the hold-off, taken several times over.
  localparam int CYCLE_LIMIT      = 1_000_000;

  typedef struct packed {
    sclru_pkg::outcome_t outcome;
    logic                second_hit;
    logic [2:0]          way_used;
    logic [31:0]         hit_total;
    logic [31:0]         miss_total;
    logic [31:0]         eviction_total;
  } access_result_t;

  // Mirror of the cache state: tags, stamps, counters and the three registers.
  // Every accepted access is played against it at once and its result queued.
  class lru_cache_mirror;
    bit               line_valid [LINES];
    logic [63:0]      line_tag   [LINES];
    logic [31:0]      line_stamp [LINES];
    logic [31:0]      stamp_now;
    logic [31:0]      hit_sum;
    logic [31:0]      miss_sum;
    logic [31:0]      evict_sum;
    logic [2:0]       set_bits_reg;
    logic [5:0]       offset_bits_reg;
    logic [3:0]       ways_reg;
    access_result_t   due_results [$];
    int               errors;

    function new();
      foreach (line_valid[k]) line_valid[k] = 1'b0;
      stamp_now       = '0;
      hit_sum         = '0;
      miss_sum        = '0;
      evict_sum       = '0;
      set_bits_reg    = sclru_pkg::SET_BITS_RST;
      offset_bits_reg = sclru_pkg::OFFSET_BITS_RST;
      ways_reg        = sclru_pkg::WAYS_RST;
      errors          = 0;
    endfunction

    function void write_register(sclru_pkg::cfg_reg_t idx,
                                 logic [sclru_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sclru_pkg::CFG_SET_BITS:    set_bits_reg    = data[2:0];
        sclru_pkg::CFG_OFFSET_BITS: offset_bits_reg = data[5:0];
        sclru_pkg::CFG_WAYS:        ways_reg        = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function logic [31:0] take_stamp();
      stamp_now = stamp_now + 32'd1;
      return stamp_now;
    endfunction

    // One pass over the set: hit, fill of the highest free way, or eviction of the
    // lowest-numbered way with the oldest stamp.
    function sclru_pkg::outcome_t lookup(int set_idx, logic [63:0] tag,
                                         output logic [2:0] way);
      int                  nways;
      int                  base;
      int                  empty_way;
      int                  victim;
      bit                  have_empty;
      bit                  have_victim;
      logic [31:0]         oldest;
      int                  pick;
      sclru_pkg::outcome_t kind;
      nways       = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg);
      base        = set_idx * MAX_WAYS;
      empty_way   = 0;
      victim      = 0;
      have_empty  = 1'b0;
      have_victim = 1'b0;
      oldest      = '0;
      for (int i = 0; i < nways; i++) begin
        if (line_valid[base + i]) begin
          if (line_tag[base + i] == tag) begin
            hit_sum = bump(hit_sum);
            line_stamp[base + i] = take_stamp();
            way = 3'(i);
            return sclru_pkg::OUT_HIT;
          end
          if (!have_victim || line_stamp[base + i] < oldest) begin
            oldest      = line_stamp[base + i];
            victim      = i;
            have_victim = 1'b1;
          end
        end else begin
          empty_way  = i;
          have_empty = 1'b1;
        end
      end
      miss_sum = bump(miss_sum);
      if (have_empty) begin
        pick = empty_way;
        kind = sclru_pkg::OUT_FILL;
      end else begin
        evict_sum = bump(evict_sum);
        pick = victim;
        kind = sclru_pkg::OUT_EVICT;
      end
      line_valid[base + pick] = 1'b1;
      line_tag[base + pick]   = tag;
      line_stamp[base + pick] = take_stamp();
      way = 3'(pick);
      return kind;
    endfunction

    function void record_access(sclru_pkg::cmd_t cmd, logic [63:0] addr);
      access_result_t r;
      int             sbits;
      int             tag_shift;
      int             set_idx;
      logic [63:0]    tag;
      logic [2:0]     way;
      logic [2:0]     spare_way;
      r.outcome    = sclru_pkg::OUT_IGNORED;
      r.second_hit = 1'b0;
      r.way_used   = '0;
      if (cmd != sclru_pkg::CMD_IFETCH) begin
        sbits     = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
        tag_shift = int'(offset_bits_reg) + sbits;
        set_idx   = int'((addr >> offset_bits_reg) & ((64'd1 << sbits) - 64'd1));
        // offset plus set bits may reach past the address: the tag is then zero
        tag       = (tag_shift >= ADDR_BITS) ? '0 : addr >> tag_shift;
        r.outcome  = lookup(set_idx, tag, way);
        r.way_used = way;
        if (cmd == sclru_pkg::CMD_MODIFY)
          r.second_hit = (lookup(set_idx, tag, spare_way) == sclru_pkg::OUT_HIT);
      end
      r.hit_total      = hit_sum;
      r.miss_total     = miss_sum;
      r.eviction_total = evict_sum;
      due_results.push_back(r);
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(access_result_t got);
      access_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result beat with no access outstanding, outcome %0d",
                 $time, got.outcome);
        errors++;
        return;
      end
      want = due_results.pop_front();
      match_field("outcome", want.outcome, got.outcome);
      match_field("second_hit", want.second_hit, got.second_hit);
      match_field("way_used", want.way_used, got.way_used);
      match_field("hit_total", want.hit_total, got.hit_total);
      match_field("miss_total", want.miss_total, got.miss_total);
      match_field("eviction_total", want.eviction_total, got.eviction_total);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  // Every input is known from time zero.
  logic                              clk          = 1'b0;
  logic                              rst_n        = 1'b0;
  logic                              in_valid     = 1'b0;
  logic                              in_ready;
  sclru_pkg::cmd_t                   in_command   = sclru_pkg::CMD_IFETCH;
  logic [ADDR_BITS-1:0]              in_address   = '0;
  logic                              out_valid;
  logic                              out_ready    = 1'b0;
  logic [sclru_pkg::OUTCOME_W-1:0]   out_outcome;
  logic                              out_second_hit;
  logic [sclru_pkg::WAY_OUT_W-1:0]   out_way_used;
  logic [sclru_pkg::TOTAL_W-1:0]     out_hit_total;
  logic [sclru_pkg::TOTAL_W-1:0]     out_miss_total;
  logic [sclru_pkg::TOTAL_W-1:0]     out_eviction_total;
  logic                              cfg_valid    = 1'b0;
  logic                              cfg_ready;
  sclru_pkg::cfg_reg_t               cfg_index    = sclru_pkg::CFG_SET_BITS;
  logic [sclru_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

  lru_cache_mirror        mirror       = new();
  access_result_t         result_beat;
  // Phase-wide knobs shared by the sender and the receiver.
  bit                     no_idle      = 1'b0;
  bit                     hold_off_req = 1'b0;
  int                     cycles_run   = 0;

  set_associative_lru_cache_model_core #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS),
    .STAMP_BITS   (STAMP_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_second_hit     (out_second_hit),
    .out_way_used       (out_way_used),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one access beat after a random gap; return at the edge that accepts it.
  // The mirror is updated here, in the driving process, so the pending count seen by
  // the stimulus never lags behind an accepted beat.
  task automatic send_access(sclru_pkg::cmd_t cmd, logic [63:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    mirror.record_access(cmd, addr);
  endtask

  // One register write beat; valid is left high for a back-to-back write.
  task automatic write_register(sclru_pkg::cfg_reg_t idx,
                                logic [sclru_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    mirror.write_register(idx, data);
  endtask

  // Drop the access valid and hold until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // Result monitor: sample the pre-edge handshake and compare against the mirror.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_beat.outcome        = sclru_pkg::outcome_t'(out_outcome);
      result_beat.second_hit     = out_second_hit;
      result_beat.way_used       = out_way_used;
      result_beat.hit_total      = out_hit_total;
      result_beat.miss_total     = out_miss_total;
      result_beat.eviction_total = out_eviction_total;
      mirror.check_result(result_beat);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request, counted here.
  initial begin : receiver
    int stall;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int              set_val;
    int              off_val;
    int              ways_val;
    int              sbits;
    int              eff_ways;
    int              tag_count;
    int              accesses;
    int              roll;
    logic [5:0]      word;
    logic [63:0]     tag_pool [16];
    logic [63:0]     set_pool [3];
    logic [63:0]     addr;
    sclru_pkg::cmd_t cmd;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: 16 sets, 16-byte blocks, 8 ways, tag = addr >> 8.
    send_access(sclru_pkg::CMD_IFETCH, '1);      // ignored, all address bits set
    send_access(sclru_pkg::CMD_LOAD, 64'h0);     // fill of the highest free way
    send_access(sclru_pkg::CMD_LOAD, 64'h0);     // hit on the same line
    send_access(sclru_pkg::CMD_STORE, 64'h0F);   // other offset, same block: hit
    send_access(sclru_pkg::CMD_MODIFY, 64'h100); // miss then a second access that hits
    for (int t = 2; t < 8; t++) send_access(sclru_pkg::CMD_LOAD, 64'(t) << 8);  // fill set 0
    send_access(sclru_pkg::CMD_STORE, 64'h800);  // set full: evict the oldest line
    send_access(sclru_pkg::CMD_MODIFY, '1);      // top set, all-ones tag
    send_access(sclru_pkg::CMD_LOAD, '1);
    send_access(sclru_pkg::CMD_IFETCH, 64'h0);
    send_access(sclru_pkg::CMD_LOAD, 64'h0);     // evicted line comes back by eviction

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();

      // The first phases walk the extremes: too many set bits, offsets that push the
      // tag shift past the address, a way count of zero and one above the maximum.
      case (phase)
        0:       begin set_val = 0; off_val = 0;  ways_val = 1;  end
        1:       begin set_val = 6; off_val = 58; ways_val = 8;  end
        2:       begin set_val = 7; off_val = 63; ways_val = 15; end
        3:       begin set_val = 5; off_val = 3;  ways_val = 0;  end
        4:       begin set_val = 4; off_val = 4;  ways_val = 8;  end
        default: begin
          set_val  = $urandom_range(7);
          off_val  = ($urandom_range(3) != 0) ? $urandom_range(10) : $urandom_range(11, 63);
          ways_val = $urandom_range(15);
        end
      endcase

      // Unused upper data bits carry noise; the block keeps only the register width.
      word = 6'($urandom());
      word[2:0] = 3'(set_val);
      write_register(sclru_pkg::CFG_SET_BITS, word);
      write_register(sclru_pkg::CFG_OFFSET_BITS, 6'(off_val));
      word = 6'($urandom());
      word[3:0] = 4'(ways_val);
      write_register(sclru_pkg::CFG_WAYS, word);
      if ($urandom_range(1) == 1) write_register(sclru_pkg::CFG_UNUSED, 6'($urandom()));
      cfg_valid <= 1'b0;

      // Phase 1 backs the block up with a long receiver hold-off; phase 4 runs flat out.
      no_idle = (phase == 4);
      if (phase == 1) hold_off_req = 1'b1;

      // A small pool of tags over a few sets keeps hits, fills and evictions all common.
      sbits     = (set_val > MAX_SET_BITS) ? MAX_SET_BITS : set_val;
      eff_ways  = (ways_val == 0) ? 1 : (ways_val > MAX_WAYS) ? MAX_WAYS : ways_val;
      tag_count = eff_ways + $urandom_range(1, 6);
      for (int i = 0; i < tag_count; i++) tag_pool[i] = {$urandom(), $urandom()};
      for (int i = 0; i < 3; i++)
        set_pool[i] = {$urandom(), $urandom()} & ((64'd1 << sbits) - 64'd1);

      accesses = 0;
      while (accesses < ACCESSES_PER_PHASE) begin
        roll = $urandom_range(99);
        cmd  = (roll < 8)  ? sclru_pkg::CMD_IFETCH :
               (roll < 38) ? sclru_pkg::CMD_LOAD :
               (roll < 68) ? sclru_pkg::CMD_STORE : sclru_pkg::CMD_MODIFY;
        if ($urandom_range(99) < 15) begin
          addr = {$urandom(), $urandom()};
        end else begin
          addr = (off_val + sbits >= ADDR_BITS) ? '0 :
                 tag_pool[$urandom_range(tag_count - 1)] << (off_val + sbits);
          addr |= set_pool[$urandom_range(2)] << off_val;
          addr |= {$urandom(), $urandom()} & ((64'd1 << off_val) - 64'd1);
        end
        send_access(cmd, addr);
        accesses++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
